// ----- rtl/gbs_pkg.sv -----
package gbs_pkg;

	localparam int KeptDepth = 32;
	localparam int MaxFrameBoxes = 4096;
	localparam int CntW = $clog2(KeptDepth + 1);
	localparam int PosW = $clog2(MaxFrameBoxes);
	localparam int OutPosW = 12;
	localparam int StepW = $clog2(KeptDepth + 4);
	localparam logic [StepW-1:0] LastStep = StepW'(KeptDepth + 2);
	localparam logic [15:0] ThresholdReset = 16'd29491;

	localparam logic CfgIdxThreshold = 1'b0;
	localparam logic CfgIdxAgnostic = 1'b1;

	typedef struct packed {
		logic       last_box;
		logic [6:0] class_label;
		logic [15:0] box_height;
		logic [15:0] box_width;
		logic [15:0] box_top;
		logic [15:0] box_left;
	} gbs_in_t;

	typedef struct packed {
		logic        frame_end;
		logic        store_overflow;
		logic [11:0] box_position;
		logic        kept;
	} gbs_out_t;

	typedef struct packed {
		logic [15:0] l;
		logic [15:0] t;
		logic [15:0] w;
		logic [15:0] h;
		logic [6:0]  label;
		logic [31:0] area;
	} gbs_entry_t;

	typedef struct packed {
		logic       valid;
		gbs_entry_t entry;
	} gbs_link_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} gbs_state_t;

endpackage

// ----- rtl/gbs_cell.sv -----
module gbs_cell
	import gbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      clear,
	input  logic      shift,
	input  logic      load,
	input  gbs_link_t load_data,
	input  gbs_link_t from_prev,
	output gbs_link_t cur
);

	gbs_entry_t entry_q;
	logic       valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_data.valid;
		end else if (shift) begin
			valid_q <= from_prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_data.entry;
		end else if (shift) begin
			entry_q <= from_prev.entry;
		end
	end

	assign cur.valid = valid_q;
	assign cur.entry = entry_q;

endmodule

// ----- rtl/gbs_iou_unit.sv -----
module gbs_iou_unit
	import gbs_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  gbs_entry_t  box,
	input  gbs_link_t   kept,
	input  logic [15:0] threshold,
	input  logic        agnostic,
	output logic        hit
);

	logic [16:0] ar, ab, er, eb, lo_x, hi_x, lo_y, hi_y;
	logic [16:0] ox, oy;
	logic [16:0] ox_s1, oy_s1;
	logic [31:0] area_a_s1, area_e_s1;
	logic        act_s1;
	logic [33:0] inter_s2;
	logic [33:0] uni_s2;
	logic        act_s2;
	logic [49:0] lhs;
	logic [49:0] rhs;

	always_comb begin
		ar = {1'b0, box.l} + {1'b0, box.w};
		ab = {1'b0, box.t} + {1'b0, box.h};
		er = {1'b0, kept.entry.l} + {1'b0, kept.entry.w};
		eb = {1'b0, kept.entry.t} + {1'b0, kept.entry.h};
		lo_x = (box.l > kept.entry.l) ? {1'b0, box.l} : {1'b0, kept.entry.l};
		hi_x = (ar < er) ? ar : er;
		lo_y = (box.t > kept.entry.t) ? {1'b0, box.t} : {1'b0, kept.entry.t};
		hi_y = (ab < eb) ? ab : eb;
		ox = (hi_x > lo_x) ? hi_x - lo_x : 17'd0;
		oy = (hi_y > lo_y) ? hi_y - lo_y : 17'd0;
	end

	always_ff @(posedge clk) begin
		ox_s1     <= ox;
		oy_s1     <= oy;
		area_a_s1 <= box.area;
		area_e_s1 <= kept.entry.area;
		act_s1    <= en && kept.valid && (agnostic || (kept.entry.label == box.label));
		inter_s2  <= {17'd0, ox_s1} * {17'd0, oy_s1};
		uni_s2    <= {2'b0, area_a_s1} + {2'b0, area_e_s1};
		act_s2    <= act_s1;
	end

	always_comb begin
		logic [33:0] u;
		u = uni_s2 - inter_s2;
		lhs = {inter_s2, 16'd0};
		rhs = {34'd0, threshold} * {16'd0, u};
		hit = act_s2 && (u != 34'd0) && (lhs > rhs);
	end

endmodule

// ----- rtl/greedy_box_suppression_core.sv -----
// Channel   Direction  Payload    Handshake
// in        input      gbs_in_t   in_valid / in_ready
// out       output     gbs_out_t  out_valid / out_ready
// cfg       input      16 bits    cfg_we, cfg_index
// A box passes from transfer to transfer through the idle state, which takes
// it, the scan state, in which the kept entries rotate once through the cell
// chain past the overlap unit, one entry a cycle, and its two register stages
// drain, and the done state, which writes the result. The result waits
// in an output register while the next box is taken; a result still held there
// stalls only the end of the next box. Reset empties the chain and clears the
// position counter.
module greedy_box_suppression_core
	import gbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  gbs_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output gbs_out_t    out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	gbs_state_t  state_q, state_d;
	logic [15:0] thr_q;
	logic        agn_q;
	gbs_entry_t  box_q;
	logic        last_q;
	logic [StepW-1:0] step_q;
	logic        drop_q;
	logic [CntW-1:0] count_q;
	logic [PosW-1:0] pos_q;
	logic        out_valid_q;
	gbs_out_t    out_q;
	logic        hit;
	logic        shift, load, clear, accept, finish, store, ovf;
	gbs_link_t   link [KeptDepth];
	gbs_link_t   ins;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign finish = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign store = finish && !drop_q && (count_q < CntW'(KeptDepth));
	assign ovf = !drop_q && (count_q >= CntW'(KeptDepth));
	assign shift = (state_q == ST_SCAN) && (step_q < StepW'(KeptDepth));
	assign load = store;
	assign clear = finish && last_q;
	assign ins.valid = 1'b1;
	assign ins.entry = box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ThresholdReset;
			agn_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgIdxThreshold: thr_q <= cfg_data;
				CfgIdxAgnostic:  agn_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_SCAN;
			ST_SCAN: if (step_q == LastStep) state_d = ST_DONE;
			ST_DONE: if (finish) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			drop_q      <= 1'b0;
			count_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
				drop_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				step_q <= step_q + 1'b1;
				if (hit) drop_q <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				if (last_q) begin
					count_q <= '0;
					pos_q   <= '0;
				end else begin
					if (store) count_q <= count_q + 1'b1;
					if (pos_q != PosW'(MaxFrameBoxes - 1)) pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			box_q.l     <= in_data.box_left;
			box_q.t     <= in_data.box_top;
			box_q.w     <= in_data.box_width;
			box_q.h     <= in_data.box_height;
			box_q.label <= in_data.class_label;
			box_q.area  <= in_data.box_width * in_data.box_height;
			last_q      <= in_data.last_box;
		end
		if (finish) begin
			out_q.kept           <= !drop_q;
			out_q.box_position   <= OutPosW'(pos_q);
			out_q.store_overflow <= ovf;
			out_q.frame_end      <= last_q;
		end
	end

	// The chain rotates: the head feeds the tail, and a new box loads at the
	// first free cell, which after a full rotation sits back at its place.
	for (genvar i = 0; i < KeptDepth; i++) begin : g_cell
		gbs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clear    (clear),
			.shift    (shift),
			.load     (load && (count_q[CntW-1:0] == CntW'(i))),
			.load_data(ins),
			.from_prev(link[(i + 1) % KeptDepth]),
			.cur      (link[i])
		);
	end

	gbs_iou_unit u_iou (
		.clk      (clk),
		.en       (shift),
		.box      (box_q),
		.kept     (link[0]),
		.threshold(thr_q),
		.agnostic (agn_q),
		.hit      (hit)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
